@@ rtl/huffman_encode_packer_unit_defines.svh @@
// Assertion macros used by the checker file of the Huffman packer.
`ifndef HUFFMAN_ENCODE_PACKER_UNIT_DEFINES_SVH
`define HUFFMAN_ENCODE_PACKER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define HEP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define HEP_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/hep_pkg.sv @@
// Shared constants and types of the Huffman encoder and byte packer.
package hep_pkg;

	localparam int unsigned SYMBOL_COUNT_DEF = 256;
	localparam int unsigned MAX_CODE_LEN_DEF = 32;
	localparam int unsigned CODE_W_MAX       = 32;
	localparam int unsigned BYTE_W           = 8;
	localparam int unsigned QUEUE_DEPTH      = 4;

	// Request opcodes; the fourth code is ignored.
	localparam logic [1:0] FUNC_WRITE  = 2'd0;
	localparam logic [1:0] FUNC_ENCODE = 2'd1;
	localparam logic [1:0] FUNC_FLUSH  = 2'd2;

	// Queue status seen by both sides
	typedef struct packed {
		logic full;
		logic empty;
	} hep_q_stat_t;

endpackage

@@ rtl/hep_front.sv @@
// Front end: request intake, code table, lookup and classification.
module hep_front import hep_pkg::*; #(
	parameter int unsigned SYMBOL_COUNT = SYMBOL_COUNT_DEF,
	parameter int unsigned CODE_W       = CODE_W_MAX,
	parameter int unsigned LEN_W        = 6
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        func,
	input  logic [7:0]        symbol,
	input  logic [31:0]       code_bits,
	input  logic [5:0]        code_length,
	input  hep_q_stat_t       q_stat,
	output logic              push,
	output logic              push_flush,
	output logic [CODE_W-1:0] push_code,
	output logic [LEN_W-1:0]  push_len
);

	localparam int unsigned SYM_W = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
	localparam int unsigned ENT_W = CODE_W + LEN_W;

	logic [SYMBOL_COUNT-1:0] valid_q;
	logic [ENT_W-1:0]        tbl_mem [SYMBOL_COUNT];
	logic                    vld_s1;
	logic                    flush_s1;
	logic [ENT_W-1:0]        ent_s1;

	logic              accept;
	logic              in_range;
	logic [SYM_W-1:0]  idx;
	logic [LEN_W-1:0]  len_c;
	logic [CODE_W-1:0] code_m;
	logic              wr_en;
	logic              enc_hit;
	logic              flush_in;

	// Intake stalls only when the lookup stage cannot drain into the queue
	assign in_ready = !vld_s1 || !q_stat.full;
	assign accept   = in_valid && in_ready;
	assign in_range = {1'b0, symbol} < 9'(SYMBOL_COUNT);
	assign idx      = symbol[SYM_W-1:0];

	// Clamp length and drop stray code bits above it
	always_comb begin
		if (code_length > 6'(CODE_W)) begin
			len_c = LEN_W'(CODE_W);
		end else begin
			len_c = code_length[LEN_W-1:0];
		end
		for (int i = 0; i < int'(CODE_W); i++) begin
			code_m[i] = code_bits[i] && (i < int'(len_c));
		end
	end

	assign wr_en    = accept && (func == FUNC_WRITE) && in_range;
	assign enc_hit  = accept && (func == FUNC_ENCODE) && in_range && valid_q[idx];
	assign flush_in = accept && (func == FUNC_FLUSH);

	// Code table: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			tbl_mem[idx] <= {len_c, code_m};
		end
		if (enc_hit) begin
			ent_s1 <= tbl_mem[idx];
		end
	end

	// Entry valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[idx] <= 1'b1;
		end
	end

	// Lookup stage in front of the queue
	assign push = vld_s1 && !q_stat.full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= enc_hit || flush_in;
		end else if (push) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			flush_s1 <= flush_in;
		end
	end

	assign push_flush = flush_s1;
	assign push_code  = ent_s1[CODE_W-1:0];
	assign push_len   = ent_s1[ENT_W-1:CODE_W];

endmodule

@@ rtl/hep_fifo.sv @@
// Short queue between the front end and the packer.
module hep_fifo import hep_pkg::*; #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output hep_q_stat_t      q_stat
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] buf_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   cnt_q;

	assign q_stat.full  = (cnt_q == (PTR_W+1)'(DEPTH));
	assign q_stat.empty = (cnt_q == '0);
	assign pop_data     = buf_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers wrap at the depth
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
		end
	end

endmodule

@@ rtl/hep_back.sv @@
// Back end: bit accumulator, byte extraction, flush and output register.
module hep_back import hep_pkg::*; #(
	parameter int unsigned CODE_W = CODE_W_MAX,
	parameter int unsigned LEN_W  = 6
) (
	input  logic              clk,
	input  logic              arst_n,
	input  hep_q_stat_t       q_stat,
	input  logic              q_flush,
	input  logic [CODE_W-1:0] q_code,
	input  logic [LEN_W-1:0]  q_len,
	output logic              q_pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        packed_byte,
	output logic              last
);

	localparam int unsigned PEND_W = BYTE_W - 1;
	localparam int unsigned ACC_W  = CODE_W + PEND_W;
	localparam int unsigned TOT_W  = $clog2(CODE_W + BYTE_W);

	logic [ACC_W-1:0] acc_q;
	logic [TOT_W-1:0] tot_q;
	logic             out_valid_q;
	logic [7:0]       byte_q;
	logic             last_q;

	logic              out_free;
	logic              have_byte;
	logic [2:0]        cnt;
	logic [PEND_W-1:0] pend;
	logic [ACC_W-1:0]  acc_new;
	logic [TOT_W-1:0]  tot_new;
	logic [TOT_W-1:0]  sh;
	logic [ACC_W-1:0]  acc_sh;
	logic [3:0]        fl_sh;
	logic [7:0]        flush_byte;
	logic              emit;
	logic [7:0]        emit_byte;
	logic              emit_last;
	logic              load;
	logic              clear;

	assign out_free  = !out_valid_q || out_ready;
	assign have_byte = int'(tot_q) >= int'(BYTE_W);
	assign cnt       = tot_q[2:0];

	// Pending bits, masked to the count
	always_comb begin
		for (int i = 0; i < int'(PEND_W); i++) begin
			pend[i] = acc_q[i] && (i < int'(cnt));
		end
	end

	// Append a code below the pending bits
	assign acc_new = (ACC_W'(pend) << q_len) | ACC_W'(q_code);
	assign tot_new = TOT_W'(cnt) + TOT_W'(q_len);

	// Oldest complete byte of the accumulator
	assign sh     = tot_q - TOT_W'(BYTE_W);
	assign acc_sh = acc_q >> sh;

	// Zero padded final byte
	assign fl_sh      = 4'(BYTE_W) - 4'(cnt);
	assign flush_byte = 8'({1'b0, pend} << fl_sh);

	// Drain bytes first, then take the next queue entry
	always_comb begin
		q_pop     = 1'b0;
		emit      = 1'b0;
		emit_byte = acc_sh[7:0];
		emit_last = int'(tot_q) < int'(2 * BYTE_W);
		load      = 1'b0;
		clear     = 1'b0;
		priority if (have_byte) begin
			emit = out_free;
		end else if (!q_stat.empty) begin
			if (q_flush) begin
				if (cnt == 3'd0) begin
					q_pop = 1'b1;
				end else if (out_free) begin
					q_pop     = 1'b1;
					emit      = 1'b1;
					emit_byte = flush_byte;
					emit_last = 1'b1;
					clear     = 1'b1;
				end
			end else begin
				q_pop = 1'b1;
				load  = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tot_q <= '0;
		end else if (load) begin
			tot_q <= tot_new;
		end else if (clear) begin
			tot_q <= '0;
		end else if (emit) begin
			tot_q <= sh;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			acc_q <= acc_new;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			byte_q <= emit_byte;
			last_q <= emit_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign packed_byte = byte_q;
	assign last        = last_q;

endmodule

@@ rtl/huffman_encode_packer_unit.sv @@
// Huffman encoder with byte packer: table lookup front end, queue, packing back end.
// Path: lookup register, queue, accumulator (encodes only) and output register.
// Throughput: one request per cycle at the input while in_ready is high; the packer
// drains all complete bytes through its single output port before taking the next entry.
// Reset: arst_n clears entry valid bits, pending bit count, queue and output valid at once.
module huffman_encode_packer_unit import hep_pkg::*; #(
	parameter int unsigned SYMBOL_COUNT = SYMBOL_COUNT_DEF,
	parameter int unsigned MAX_CODE_LEN = MAX_CODE_LEN_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  func,
	input  logic [7:0]  symbol,
	input  logic [31:0] code_bits,
	input  logic [5:0]  code_length,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  packed_byte,
	output logic        last
);

	localparam int unsigned CODE_W = (MAX_CODE_LEN < CODE_W_MAX) ? MAX_CODE_LEN : CODE_W_MAX;
	localparam int unsigned LEN_W  = $clog2(CODE_W + 1);
	localparam int unsigned Q_W    = 1 + LEN_W + CODE_W;

	hep_q_stat_t       q_stat;
	logic              push;
	logic              push_flush;
	logic [CODE_W-1:0] push_code;
	logic [LEN_W-1:0]  push_len;
	logic              pop;
	logic [Q_W-1:0]    pop_data;

	hep_front #(
		.SYMBOL_COUNT (SYMBOL_COUNT),
		.CODE_W       (CODE_W),
		.LEN_W        (LEN_W)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.func        (func),
		.symbol      (symbol),
		.code_bits   (code_bits),
		.code_length (code_length),
		.q_stat      (q_stat),
		.push        (push),
		.push_flush  (push_flush),
		.push_code   (push_code),
		.push_len    (push_len)
	);

	hep_fifo #(
		.WIDTH (Q_W),
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({push_flush, push_len, push_code}),
		.pop       (pop),
		.pop_data  (pop_data),
		.q_stat    (q_stat)
	);

	hep_back #(
		.CODE_W (CODE_W),
		.LEN_W  (LEN_W)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_stat      (q_stat),
		.q_flush     (pop_data[Q_W-1]),
		.q_code      (pop_data[CODE_W-1:0]),
		.q_len       (pop_data[Q_W-2:CODE_W]),
		.q_pop       (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.packed_byte (packed_byte),
		.last        (last)
	);

endmodule

@@ rtl/hep_chk.sv @@
// Port-level checker for the Huffman packer, bound to the top level.
`include "huffman_encode_packer_unit_defines.svh"

module hep_chk import hep_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [1:0]  func,
	input logic [7:0]  symbol,
	input logic [31:0] code_bits,
	input logic [5:0]  code_length,
	input logic        out_valid,
	input logic        out_ready,
	input logic [7:0]  packed_byte,
	input logic        last
);

	logic        seen_q;
	logic [31:0] open_q;
	logic        take_req;
	logic        take_last;

	// Requests that may produce bytes, and closing bytes delivered
	assign take_req  = in_valid && in_ready && ((func == FUNC_ENCODE) || (func == FUNC_FLUSH));
	assign take_last = out_valid && out_ready && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 1'b0;
			open_q <= '0;
		end else begin
			if (take_req) begin
				seen_q <= 1'b1;
			end
			open_q <= open_q + 32'(take_req) - 32'(take_last);
		end
	end

	`HEP_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(packed_byte) && $stable(last), "output request changed while stalled")
	`HEP_ASSERT_IMP(a_out_drop, $fell(out_valid), $past(out_ready), "output request dropped without being taken")
	`HEP_ASSERT_IMP(a_no_early, out_valid, seen_q, "byte emitted before any encode or flush")
	`HEP_ASSERT_IMP(a_last_cnt, out_valid && last, open_q != 32'd0, "closing byte without an open request")

endmodule

bind huffman_encode_packer_unit hep_chk u_hep_chk (.*);
